// ===== rtl/psbb_pkg.sv =====
// Shared constants and types for the point set bounding box block.
package psbb_pkg;

  localparam int CAPACITY   = 1024;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ENTRY_W    = 1 + 2 * COORD_BITS;
  localparam int CMP_W      = 33;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_QUERY  = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_RECT   = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  // Unassigned codes: no action, result reports the count only.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
  } entry_t;

  typedef enum logic [1:0] {
    BS_EMPTY = 2'd0,
    BS_VALID = 2'd1,
    BS_STALE = 2'd2
  } bstat_t;

endpackage

// ===== rtl/point_set_bounding_box.sv =====
// Point set with bounding box: top level, sequencer and table scanner.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one command word: operation,
//   point or rectangle corner, and rectangle size. Output channel
//   (out_valid/out_ready) returns one result word per command.
// - The point table lives in one RAM of CAPACITY entries (valid, x, y).
//   Add, remove, query and remove-in-rectangle walk the whole table through
//   the single read port. Clear sweeps the table through the write port.
//   Read box answers straight from the stored box when it is current, and
//   rebuilds it by a table walk when it is stale. Unused codes go straight
//   to the finish step.
// - One command is in flight at a time; throughput is set by the table walk.
// - After reset the block sweeps every RAM entry invalid, and holds
//   in_ready low until the sweep ends.
// - The result sits in an output register. A new command is accepted while
//   a result waits; if the receiver stalls, the next result holds in the
//   finish step until the output register frees up.
module point_set_bounding_box
  import psbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic signed [15:0] in_x_coord,
  input  logic signed [15:0] in_y_coord,
  input  logic [15:0] in_rect_width,
  input  logic [15:0] in_rect_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic        out_table_full,
  output logic [10:0] out_point_count,
  output logic signed [15:0] out_box_left,
  output logic signed [15:0] out_box_top,
  output logic [16:0] out_box_span_x,
  output logic [16:0] out_box_span_y
);

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_SCAN, S_FIN} state_t;

  state_t           state_r;
  logic [2:0]       op_r;
  coord_t           px_r, py_r;
  logic [15:0]      rw_r, rh_r;
  logic [IDX_W:0]   scan_cnt_r;
  logic             clr_fin_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             match_r, free_r, hit_r, any_r;
  logic [IDX_W-1:0] match_idx_r, free_idx_r;
  coord_t           amnx_r, amxx_r, amny_r, amxy_r;
  coord_t           bmnx_r, bmxx_r, bmny_r, bmxy_r;
  bstat_t           stat_r;
  logic [CNT_W-1:0] cnt_r;

  logic             out_valid_r, out_hit_r, out_full_r;
  logic [10:0]      out_cnt_r;
  logic signed [15:0] out_left_r, out_top_r;
  logic [16:0]      out_spx_r, out_spy_r;

  // RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata, rd_ent;
  logic [ENTRY_W-1:0] ram_rdata;

  psbb_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  // Rectangle test without overflow: widen, subtract the corner, compare.
  logic signed [CMP_W-1:0] dx, dy;
  logic rd_inside, rd_same, out_ok;

  assign dx = CMP_W'(rd_ent.x) - CMP_W'(px_r);
  assign dy = CMP_W'(rd_ent.y) - CMP_W'(py_r);
  assign rd_inside = rd_ent.valid && !dx[CMP_W-1] && !dy[CMP_W-1] &&
                     (dx < $signed(CMP_W'(rw_r))) && (dy < $signed(CMP_W'(rh_r)));
  assign rd_same   = rd_ent.valid && (rd_ent.x == px_r) && (rd_ent.y == py_r);
  assign out_ok    = !out_valid_r || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_cnt_r[IDX_W-1:0];
    ram_wdata = '0;
    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        if (rd_vld_r && op_r == OP_RECT && rd_inside) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r;
        end
      end
      S_FIN: begin
        if (out_ok && op_r == OP_ADD && !match_r && free_r) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx_r;
          ram_wdata = '{valid: 1'b1, x: px_r, y: py_r};
        end else if (out_ok && op_r == OP_REMOVE && match_r) begin
          ram_we    = 1'b1;
          ram_waddr = match_idx_r;
        end
      end
      default: ;
    endcase
  end

  // Finish step: final count, status, box and result flags.
  logic [CNT_W-1:0] fin_cnt;
  bstat_t           fin_stat;
  logic             fin_hit, fin_full, fin_show;
  coord_t           fin_mnx, fin_mxx, fin_mny, fin_mxy;

  always_comb begin
    fin_cnt  = cnt_r;
    fin_stat = stat_r;
    fin_hit  = 1'b0;
    fin_full = 1'b0;
    fin_show = 1'b0;
    fin_mnx  = bmnx_r;
    fin_mxx  = bmxx_r;
    fin_mny  = bmny_r;
    fin_mxy  = bmxy_r;
    case (op_r)
      OP_ADD: begin
        if (!match_r) begin
          if (!free_r) begin
            fin_full = 1'b1;
          end else begin
            fin_cnt = cnt_r + 1'b1;
            fin_hit = 1'b1;
            if (stat_r == BS_EMPTY) begin
              fin_stat = BS_VALID;
              fin_mnx  = px_r;
              fin_mxx  = px_r;
              fin_mny  = py_r;
              fin_mxy  = py_r;
            end else if (stat_r == BS_VALID) begin
              if (px_r < bmnx_r) fin_mnx = px_r;
              if (px_r > bmxx_r) fin_mxx = px_r;
              if (py_r < bmny_r) fin_mny = py_r;
              if (py_r > bmxy_r) fin_mxy = py_r;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (match_r) begin
          fin_cnt = cnt_r - 1'b1;
          fin_hit = 1'b1;
          if (stat_r == BS_VALID) begin
            fin_stat = (cnt_r == CNT_W'(1)) ? BS_EMPTY : BS_STALE;
          end
        end
      end
      OP_QUERY: fin_hit = match_r;
      OP_CLEAR: begin
        fin_cnt  = '0;
        fin_stat = BS_EMPTY;
      end
      OP_RECT: fin_hit = hit_r;
      OP_READ: begin
        if (stat_r == BS_STALE) begin
          fin_stat = any_r ? BS_VALID : BS_EMPTY;
          fin_mnx  = amnx_r;
          fin_mxx  = amxx_r;
          fin_mny  = amny_r;
          fin_mxy  = amxy_r;
        end
        fin_show = (fin_stat == BS_VALID);
      end
      default: ;
    endcase
  end

  logic [COORD_BITS:0] span_x, span_y;
  assign span_x = (COORD_BITS+1)'(fin_mxx) - (COORD_BITS+1)'(fin_mnx) + 1'b1;
  assign span_y = (COORD_BITS+1)'(fin_mxy) - (COORD_BITS+1)'(fin_mny) + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      scan_cnt_r  <= '0;
      clr_fin_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      stat_r      <= BS_EMPTY;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the word once taken; the finish step reloads it itself
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          // sweep one entry a cycle
          if (scan_cnt_r == (IDX_W+1)'(CAPACITY - 1)) begin
            scan_cnt_r <= '0;
            state_r    <= clr_fin_r ? S_FIN : S_IDLE;
          end else begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= in_operation;
            px_r       <= coord_t'(in_x_coord[COORD_BITS-1:0]);
            py_r       <= coord_t'(in_y_coord[COORD_BITS-1:0]);
            rw_r       <= in_rect_width;
            rh_r       <= in_rect_height;
            match_r    <= 1'b0;
            free_r     <= 1'b0;
            hit_r      <= 1'b0;
            any_r      <= 1'b0;
            scan_cnt_r <= '0;
            clr_fin_r  <= 1'b1;
            if (in_operation == OP_CLEAR) begin
              state_r <= S_CLR;
            end else if ((in_operation == OP_READ && stat_r != BS_STALE) ||
                         in_operation > OP_READ) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue reads in order, handle the entry that arrives
          if (scan_cnt_r != (IDX_W+1)'(CAPACITY)) begin
            rd_vld_r   <= 1'b1;
            rd_idx_r   <= scan_cnt_r[IDX_W-1:0];
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
            if (!rd_vld_r) begin
              state_r <= S_FIN;
            end
          end
          if (rd_vld_r) begin
            if (rd_same) begin
              match_r     <= 1'b1;
              match_idx_r <= rd_idx_r;
            end
            if (!rd_ent.valid && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= rd_idx_r;
            end
            if (op_r == OP_RECT && rd_inside) begin
              cnt_r <= cnt_r - 1'b1;
              hit_r <= 1'b1;
              if (stat_r == BS_VALID) begin
                stat_r <= (cnt_r == CNT_W'(1)) ? BS_EMPTY : BS_STALE;
              end
            end
            if (rd_ent.valid) begin
              any_r <= 1'b1;
              if (!any_r || rd_ent.x < amnx_r) amnx_r <= rd_ent.x;
              if (!any_r || rd_ent.x > amxx_r) amxx_r <= rd_ent.x;
              if (!any_r || rd_ent.y < amny_r) amny_r <= rd_ent.y;
              if (!any_r || rd_ent.y > amxy_r) amxy_r <= rd_ent.y;
            end
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_ok) begin
            cnt_r       <= fin_cnt;
            stat_r      <= fin_stat;
            bmnx_r      <= fin_mnx;
            bmxx_r      <= fin_mxx;
            bmny_r      <= fin_mny;
            bmxy_r      <= fin_mxy;
            out_valid_r <= 1'b1;
            out_hit_r   <= fin_hit;
            out_full_r  <= fin_full;
            out_cnt_r   <= 11'(fin_cnt);
            out_left_r  <= fin_show ? 16'(fin_mnx) : '0;
            out_top_r   <= fin_show ? 16'(fin_mny) : '0;
            out_spx_r   <= fin_show ? 17'(span_x) : '0;
            out_spy_r   <= fin_show ? 17'(span_y) : '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_table_full  = out_full_r;
  assign out_point_count = out_cnt_r;
  assign out_box_left    = out_left_r;
  assign out_box_top     = out_top_r;
  assign out_box_span_x  = out_spx_r;
  assign out_box_span_y  = out_spy_r;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("point count above capacity");
  a_valid_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stat_r == BS_VALID |-> cnt_r != '0)
    else $error("valid box with no points");
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word not from finish step");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !ram_we)
    else $error("table write while idle");
`endif

endmodule

// ===== rtl/psbb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for point_set_bounding_box: directed and random words against a scoreboard.
`timescale 1ns / 1ps

module tb;
  import psbb_pkg::*;

  // Cap on cycles without any handshake. The slowest word is a table walk
  // plus the longest output stall, far below this.
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    bit          hit;
    bit          full;
    bit [10:0]   count;
    bit [15:0]   left;
    bit [15:0]   top;
    bit [16:0]   span_x;
    bit [16:0]   span_y;
  } result_t;

  // Scoreboard: mirrors the point set and its box, queues expected results.
  class point_set_scoreboard;
    bit          points[bit [31:0]];
    int          count;
    longint      b_left, b_top, b_sx, b_sy;
    bstat_t      b_stat;
    result_t     pending_results[$];
    int          errors;

    function void clear_box();
      b_left = 0; b_top = 0; b_sx = 0; b_sy = 0; b_stat = BS_EMPTY;
    endfunction

    function void drop_point(bit [31:0] key);
      points.delete(key);
      count--;
      if (b_stat == BS_VALID) begin
        if (count == 0) clear_box();
        else b_stat = BS_STALE;
      end
    endfunction

    function void grow_box(longint x, longint y);
      longint r, b;
      if (b_stat == BS_STALE) return;
      if (b_stat == BS_EMPTY) begin
        b_left = x; b_top = y; b_sx = 1; b_sy = 1; b_stat = BS_VALID;
        return;
      end
      r = b_left + b_sx - 1;
      b = b_top + b_sy - 1;
      if (x < b_left) b_left = x;
      if (x > r) r = x;
      if (y < b_top) b_top = y;
      if (y > b) b = y;
      b_sx = r - b_left + 1;
      b_sy = b - b_top + 1;
    endfunction

    function void rebuild_box();
      longint minx, maxx, miny, maxy, px, py;
      bit any;
      any = 0; minx = 0; maxx = 0; miny = 0; maxy = 0;
      foreach (points[k]) begin
        px = longint'($signed(k[31:16]));
        py = longint'($signed(k[15:0]));
        if (!any || px < minx) minx = px;
        if (!any || px > maxx) maxx = px;
        if (!any || py < miny) miny = py;
        if (!any || py > maxy) maxy = py;
        any = 1;
      end
      if (!any) begin
        clear_box();
        return;
      end
      b_left = minx; b_top = miny;
      b_sx = maxx - minx + 1; b_sy = maxy - miny + 1;
      b_stat = BS_VALID;
    endfunction

    // Apply one accepted word to the mirror and queue its result.
    function void note_word(logic [2:0] op, logic signed [15:0] x, logic signed [15:0] y,
                            logic [15:0] w, logic [15:0] h);
      result_t r;
      bit [31:0] key, victims[$];
      longint px, py;
      r = '{default: 0};
      key = {x, y};
      case (op)
        OP_ADD: begin
          if (!points.exists(key)) begin
            if (count >= CAPACITY) r.full = 1;
            else begin
              points[key] = 1;
              count++;
              r.hit = 1;
              grow_box(longint'(x), longint'(y));
            end
          end
        end
        OP_REMOVE: begin
          if (points.exists(key)) begin
            drop_point(key);
            r.hit = 1;
          end
        end
        OP_QUERY: r.hit = (points.exists(key) != 0);
        OP_CLEAR: begin
          points.delete();
          count = 0;
          clear_box();
        end
        OP_RECT: begin
          foreach (points[k]) begin
            px = longint'($signed(k[31:16]));
            py = longint'($signed(k[15:0]));
            if (px >= longint'(x) && px < longint'(x) + longint'(w) &&
                py >= longint'(y) && py < longint'(y) + longint'(h))
              victims.push_back(k);
          end
          foreach (victims[i]) drop_point(victims[i]);
          r.hit = victims.size() != 0;
        end
        OP_READ: begin
          if (b_stat == BS_STALE) rebuild_box();
          if (b_stat == BS_VALID) begin
            r.left = b_left[15:0]; r.top = b_top[15:0];
            r.span_x = b_sx[16:0]; r.span_y = b_sy[16:0];
          end
        end
        default: ;
      endcase
      r.count = count[10:0];
      pending_results.push_back(r);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.hit != want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
      end
      if (got.full != want.full) begin
        $error("table_full: expected %0d, got %0d", want.full, got.full); errors++;
      end
      if (got.count != want.count) begin
        $error("point_count: expected %0d, got %0d", want.count, got.count); errors++;
      end
      if (got.left != want.left) begin
        $error("box_left: expected %0h, got %0h", want.left, got.left); errors++;
      end
      if (got.top != want.top) begin
        $error("box_top: expected %0h, got %0h", want.top, got.top); errors++;
      end
      if (got.span_x != want.span_x) begin
        $error("box_span_x: expected %0h, got %0h", want.span_x, got.span_x); errors++;
      end
      if (got.span_y != want.span_y) begin
        $error("box_span_y: expected %0h, got %0h", want.span_y, got.span_y); errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [2:0]         in_operation = '0;
  logic signed [15:0] in_x_coord = '0;
  logic signed [15:0] in_y_coord = '0;
  logic [15:0]        in_rect_width = '0;
  logic [15:0]        in_rect_height = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic               out_hit;
  logic               out_table_full;
  logic [10:0]        out_point_count;
  logic signed [15:0] out_box_left;
  logic signed [15:0] out_box_top;
  logic [16:0]        out_box_span_x;
  logic [16:0]        out_box_span_y;

  point_set_scoreboard sb = new();
  bit calm = 0;          // set for the last part of the run: no idling
  int out_hold = 0;
  int quiet_cycles = 0;

  point_set_bounding_box dut (.*);

  always #5 clk = ~clk;

  // Receiver: stall in random bursts, check every accepted word.
  always @(posedge clk) begin
    result_t got;
    logic    rdy;
    if (rst_n && out_valid && out_ready) begin
      got.hit = out_hit; got.full = out_table_full; got.count = out_point_count;
      got.left = out_box_left; got.top = out_box_top;
      got.span_x = out_box_span_x; got.span_y = out_box_span_y;
      sb.check_word(got);
    end
    rdy = 1;
    if (out_hold > 0) begin
      out_hold--;
      rdy = 0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(1, 7) - 1;
      rdy = 0;
    end
    out_ready <= rdy;
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Send one command word; hold valid and payload until accepted.
  task automatic send_word(logic [2:0] op, logic signed [15:0] x, logic signed [15:0] y,
                           logic [15:0] w = 0, logic [15:0] h = 0);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1;
    in_operation   <= op;
    in_x_coord     <= x;
    in_y_coord     <= y;
    in_rect_width  <= w;
    in_rect_height <= h;
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, x, y, w, h);
  endtask

  // Mostly small coordinates so points collide; sometimes full range.
  function automatic logic [15:0] pick_coord();
    if ($urandom_range(0, 9) < 8) return 16'($signed($urandom_range(0, 16)) - 8);
    return 16'($urandom);
  endfunction

  initial begin
    logic [2:0] op;
    int roll;
    logic signed [15:0] rx, ry;
    sb.clear_box();
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, every operation, box corner cases.
    send_word(OP_READ, 0, 0);                       // empty box reads zero
    send_word(OP_ADD, 16'sh8000, 16'sh8000);
    send_word(OP_ADD, 16'sh7fff, 16'sh7fff);
    send_word(OP_READ, 0, 0);                       // full-span box
    send_word(OP_ADD, 16'sh7fff, 16'sh7fff);        // duplicate add
    send_word(OP_QUERY, 16'sh7fff, 16'sh7fff);
    send_word(OP_QUERY, 1, 2);
    send_word(OP_REMOVE, 16'sh7fff, 16'sh7fff);     // box goes stale
    send_word(OP_ADD, 3, -4);                       // add while stale
    send_word(OP_READ, 0, 0);                       // rebuild
    send_word(OP_RECT, 16'sh8000, 16'sh8000, 0, 16'hffff);  // zero width
    send_word(OP_RECT, 16'sh8000, 16'sh8000, 16'hffff, 0);  // zero height
    send_word(OP_RECT, 0, -10, 10, 10);
    send_word(OP_RECT, 16'sh8000, 16'sh8000, 16'hffff, 16'hffff);
    send_word(OP_READ, 0, 0);                       // stale, no points left
    send_word(OP_ADD, 5, 5);
    send_word(OP_REMOVE, 5, 5);                     // valid box emptied
    send_word(OP_REMOVE, 5, 5);
    send_word(OP_READ, 0, 0);
    send_word(OP_ADD, -1, 7);
    send_word(OP_SPARE_A, 16'sh5555, 16'shaaaa, 16'h5555, 16'haaaa);
    send_word(OP_SPARE_B, 16'shaaaa, 16'sh5555, 16'haaaa, 16'h5555);
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_READ, 0, 0);

    // Fill the table, then hit it with an add that must be dropped.
    for (int i = 0; i < CAPACITY; i++) send_word(OP_ADD, 16'(i - 512), 16'(300 - i));
    send_word(OP_ADD, 16'sh1234, 16'sh4321);
    send_word(OP_ADD, -512, 300);
    send_word(OP_READ, 0, 0);
    send_word(OP_RECT, -512, -723, 200, 16'hffff);
    send_word(OP_ADD, 16'sh1234, 16'sh4321);
    send_word(OP_READ, 0, 0);
    send_word(OP_CLEAR, 0, 0);

    // Random: add-heavy mix over a small coordinate pool.
    for (int n = 0; n < 40; n++) begin
      if (n == 30) calm = 1;
      roll = $urandom_range(0, 99);
      if (roll < 40) op = OP_ADD;
      else if (roll < 55) op = OP_REMOVE;
      else if (roll < 68) op = OP_QUERY;
      else if (roll < 80) op = OP_READ;
      else if (roll < 92) op = OP_RECT;
      else if (roll < 96) op = OP_CLEAR;
      else op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
      rx = pick_coord();
      ry = pick_coord();
      if (op == OP_RECT && $urandom_range(0, 4) != 0)
        send_word(op, rx, ry, 16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
      else
        send_word(op, rx, ry, 16'($urandom), 16'($urandom));
    end
    in_valid <= 0;

    // Drain, then let the block settle before the verdict.
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 20) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/psbb_pkg.sv
rtl/psbb_ram.sv
rtl/point_set_bounding_box.sv
tb/sv/tb.sv
